// ===== sv/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 stream codec.
package b64_pkg;

	localparam logic [6:0] PAD_CODE = 7'd64;
	localparam logic [6:0] BAD_CODE = 7'd65;
	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int unsigned MAX_BEATS = 4;
	localparam int unsigned CNT_W = $clog2(MAX_BEATS + 1);
	localparam int unsigned IDX_W = $clog2(MAX_BEATS);

	// results produced by one input beat, first one in bytes[0]
	typedef struct packed {
		logic [MAX_BEATS-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      bad;
	} b64_grp_t;

	function automatic logic [7:0] char_of(input logic [5:0] six);
		logic [7:0] s;
		s = {2'b00, six};
		if (six < 6'd26) begin
			return 8'h41 + s;
		end else if (six < 6'd52) begin
			return 8'h61 + s - 8'd26;
		end else if (six < 6'd62) begin
			return 8'h30 + s - 8'd52;
		end else if (six == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

	// 0..63 for alphabet characters, PAD_CODE for '=', BAD_CODE otherwise
	function automatic logic [6:0] value_of(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) begin
			return 7'(c - 8'h41);
		end else if (c inside {[8'h61:8'h7A]}) begin
			return 7'(c - 8'h61 + 8'd26);
		end else if (c inside {[8'h30:8'h39]}) begin
			return 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			return 7'd62;
		end else if (c == 8'h2F) begin
			return 7'd63;
		end else if (c == PAD_CHAR) begin
			return PAD_CODE;
		end else begin
			return BAD_CODE;
		end
	endfunction

endpackage

// ===== sv/b64_core.sv =====
// Group state and per-beat encode/decode logic of the Base64 codec.
module b64_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              item_accept,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output b64_pkg::b64_grp_t grp
);
	import b64_pkg::*;

	logic        dir_q;
	logic [23:0] gb_q;
	logic [1:0]  gc_q;
	logic [1:0]  pc_q;

	logic [23:0] gb_nxt;
	logic [1:0]  gc_nxt;
	logic [1:0]  pc_nxt;

	logic [23:0] gb_enc;
	logic [1:0]  gc_enc;
	logic [6:0]  val;
	logic        is_pad;
	logic        is_bad;
	logic [1:0]  pc_dec;
	logic [23:0] gb_dec;

	always_comb begin
		gb_enc = {gb_q[15:0], in_byte};
		gc_enc = gc_q + 2'd1;
		val    = value_of(in_byte);
		is_pad = (val == PAD_CODE);
		is_bad = (val == BAD_CODE) || (is_pad && gc_q < 2'd2) || (!is_pad && pc_q != 2'd0);
		pc_dec = is_pad ? pc_q + 2'd1 : pc_q;
		gb_dec = {gb_q[17:0], (is_pad ? 6'd0 : val[5:0])};

		grp    = '0;
		gb_nxt = '0;
		gc_nxt = '0;
		pc_nxt = '0;

		if (!dir_q) begin
			if (gc_enc == 2'd3) begin
				grp.bytes[0] = char_of(gb_enc[23:18]);
				grp.bytes[1] = char_of(gb_enc[17:12]);
				grp.bytes[2] = char_of(gb_enc[11:6]);
				grp.bytes[3] = char_of(gb_enc[5:0]);
				grp.cnt      = CNT_W'(4);
			end else if (in_last) begin
				if (gc_enc == 2'd1) begin
					grp.bytes[0] = char_of(gb_enc[7:2]);
					grp.bytes[1] = char_of({gb_enc[1:0], 4'b0000});
					grp.bytes[2] = PAD_CHAR;
				end else begin
					grp.bytes[0] = char_of(gb_enc[15:10]);
					grp.bytes[1] = char_of(gb_enc[9:4]);
					grp.bytes[2] = char_of({gb_enc[3:0], 2'b00});
				end
				grp.bytes[3] = PAD_CHAR;
				grp.cnt      = CNT_W'(4);
			end else begin
				gb_nxt = gb_enc;
				gc_nxt = gc_enc;
				pc_nxt = pc_q;
			end
		end else begin
			if (is_bad) begin
				grp.cnt = CNT_W'(1);
				grp.bad = 1'b1;
			end else if (gc_q == 2'd3) begin
				grp.bytes[0] = gb_dec[23:16];
				grp.bytes[1] = gb_dec[15:8];
				grp.bytes[2] = gb_dec[7:0];
				grp.cnt      = CNT_W'(3) - CNT_W'(pc_dec);
			end else if (in_last) begin
				// truncated final group
				grp.cnt = CNT_W'(1);
				grp.bad = 1'b1;
			end else begin
				gb_nxt = gb_dec;
				gc_nxt = gc_q + 2'd1;
				pc_nxt = pc_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			gb_q  <= '0;
			gc_q  <= '0;
			pc_q  <= '0;
		end else if (cfg_we) begin
			dir_q <= cfg_wdata;
			gb_q  <= '0;
			gc_q  <= '0;
			pc_q  <= '0;
		end else if (item_accept) begin
			gb_q <= gb_nxt;
			gc_q <= gc_nxt;
			pc_q <= pc_nxt;
		end
	end

endmodule

// ===== sv/b64_outq.sv =====
// Result register that holds one beat's results and sends them out one at a time.
module b64_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64_pkg::b64_grp_t grp,
	output logic              can_load,
	output logic              m_valid,
	input  logic              m_ready,
	output logic [7:0]        m_byte,
	output logic              m_last,
	output logic              m_bad
);
	import b64_pkg::*;

	logic [MAX_BEATS-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      bad_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      valid_q;
	logic                      last_beat;

	assign m_valid   = valid_q;
	assign m_byte    = bytes_q[idx_q];
	assign m_bad     = bad_q;
	assign m_last    = (CNT_W'(idx_q) + CNT_W'(1)) == cnt_q;
	assign last_beat = valid_q && m_ready && m_last;
	assign can_load  = !valid_q || last_beat;

	always_ff @(posedge clk) begin
		if (load && grp.cnt != '0) begin
			bytes_q <= grp.bytes;
			cnt_q   <= grp.cnt;
			bad_q   <= grp.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load && grp.cnt != '0) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (last_beat) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (valid_q && m_ready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

// ===== sv/base64_codec_stream.sv =====
// The first result of an input beat is offered in the cycle after the beat is taken.
// Throughput: one input beat per cycle while no results are pending; a beat that yields
// results blocks the input until its last result goes out.
// Reset: arst_n clears direction (encode), the group state and the result register's valid flag and index.
// Top level of the Base64 stream codec.
module base64_codec_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,     // direction: 0 encode, 1 decode
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic       m_axis_tuser   // [0] bad_input
);
	import b64_pkg::*;

	b64_grp_t grp;
	logic     accept;
	logic     can_load;

	assign s_axis_tready = can_load;
	assign accept        = s_axis_tvalid && can_load;

	b64_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item_accept (accept),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.grp         (grp)
	);

	b64_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.grp      (grp),
		.can_load (can_load),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_byte   (m_axis_tdata),
		.m_last   (m_axis_tlast),
		.m_bad    (m_axis_tuser)
	);

endmodule

// ===== sv/b64_checker.sv =====
// Port-level checks for the Base64 stream codec, bound to the top level.
module b64_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// an error beat is always a lone zero beat
	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00 && m_axis_tlast)
		else $error("error beat not a lone zero beat");

	// input is held while a result group is still draining
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken while results still pending");

	// with nothing to send, input is always open
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output beat changed");

endmodule

bind base64_codec_stream b64_checker u_b64_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
